/* sv/cesd_pkg.sv */
`default_nettype none

package cesd_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } mode_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic [15:0] out_count;
        logic        end_of_string;
    } out_item_t;

    typedef struct packed {
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
    } dec_res_t;

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {valid, decoded byte}
    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h72:   r = {1'b1, 8'h0D};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h74:   r = {1'b1, 8'h09};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h66:   r = {1'b1, 8'h0C};
            8'h62:   r = {1'b1, 8'h08};
            8'h76:   r = {1'b1, 8'h0B};
            8'h61:   r = {1'b1, 8'h07};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cesd_decode.sv */
`default_nettype none

module cesd_decode #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire cesd_pkg::in_item_t item,
    input  wire logic [15:0]        output_limit,
    output cesd_pkg::dec_res_t      res
);

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    cesd_pkg::mode_t        mode_reg, mode_next;
    logic [7:0]             value_reg, value_next;
    logic [1:0]             digits_reg, digits_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count1;

    logic [7:0] c;
    logic       last;
    logic       is_oct;
    logic [4:0] hexv;
    logic [8:0] escv;
    logic [1:0] digits_inc;

    logic       e0_vld, e1_vld;
    logic [7:0] e0_byte, e1_byte;
    logic       keep0, keep1;
    logic [CMPW-1:0] cnt_x, cnt1_x, lim_x, cnt_p1_x, cnt_p2_x;

    assign c          = item.in_byte;
    assign last       = item.last_byte;
    assign is_oct     = c inside {[8'h30:8'h37]};
    assign hexv       = cesd_pkg::hex_val(c);
    assign escv       = cesd_pkg::esc_val(c);
    assign digits_inc = digits_reg + 2'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        case (mode_reg)
            cesd_pkg::MODE_PLAIN:
            begin
                if (c == cesd_pkg::CH_BACKSLASH)
                begin
                    mode_next = cesd_pkg::MODE_ESC;
                end
            end
            cesd_pkg::MODE_ESC:
            begin
                mode_next = cesd_pkg::MODE_PLAIN;
                if (!escv[8])
                begin
                    if (c == cesd_pkg::CH_X)
                    begin
                        mode_next   = cesd_pkg::MODE_HEX;
                        value_next  = 8'd0;
                        digits_next = 2'd0;
                    end
                    else if (is_oct)
                    begin
                        mode_next   = cesd_pkg::MODE_OCT;
                        value_next  = {5'd0, c[2:0]};
                        digits_next = 2'd1;
                    end
                end
            end
            cesd_pkg::MODE_HEX:
            begin
                if (hexv[4])
                begin
                    if (digits_reg == 2'd0)
                    begin
                        value_next  = {4'd0, hexv[3:0]};
                        digits_next = 2'd1;
                    end
                    else
                    begin
                        mode_next = cesd_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    mode_next = (c == cesd_pkg::CH_BACKSLASH) ? cesd_pkg::MODE_ESC
                                                              : cesd_pkg::MODE_PLAIN;
                end
            end
            cesd_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    value_next  = {value_reg[4:0], c[2:0]};
                    digits_next = digits_inc;
                    if (digits_inc == 2'd3)
                    begin
                        mode_next = cesd_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    mode_next = (c == cesd_pkg::CH_BACKSLASH) ? cesd_pkg::MODE_ESC
                                                              : cesd_pkg::MODE_PLAIN;
                end
            end
            default:
            begin
                mode_next = cesd_pkg::MODE_PLAIN;
            end
        endcase
    end

    always_comb
    begin
        e0_vld  = 1'b0;
        e0_byte = c;
        e1_vld  = 1'b0;
        e1_byte = c;
        case (mode_reg)
            cesd_pkg::MODE_PLAIN:
            begin
                e0_vld = (c != cesd_pkg::CH_BACKSLASH);
            end
            cesd_pkg::MODE_ESC:
            begin
                if (escv[8])
                begin
                    e0_vld  = 1'b1;
                    e0_byte = escv[7:0];
                end
                else
                begin
                    e0_vld = (c != cesd_pkg::CH_X) && !is_oct;
                end
            end
            cesd_pkg::MODE_HEX:
            begin
                if (hexv[4])
                begin
                    e0_vld  = (digits_reg != 2'd0);
                    e0_byte = {value_reg[3:0], hexv[3:0]};
                end
                else
                begin
                    e0_vld  = 1'b1;
                    e0_byte = (digits_reg != 2'd0) ? value_reg : cesd_pkg::CH_X;
                    e1_vld  = (c != cesd_pkg::CH_BACKSLASH);
                end
            end
            cesd_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    e0_vld  = (digits_inc == 2'd3);
                    e0_byte = {value_reg[4:0], c[2:0]};
                end
                else
                begin
                    e0_vld  = 1'b1;
                    e0_byte = value_reg;
                    e1_vld  = (c != cesd_pkg::CH_BACKSLASH);
                end
            end
            default:
            begin
                e0_vld = 1'b0;
            end
        endcase
        // flush a pending hex or octal escape on the final character
        if (last && mode_next == cesd_pkg::MODE_HEX)
        begin
            e0_vld  = 1'b1;
            e0_byte = (digits_next != 2'd0) ? value_next : cesd_pkg::CH_X;
        end
        else if (last && mode_next == cesd_pkg::MODE_OCT)
        begin
            e0_vld  = 1'b1;
            e0_byte = value_next;
        end
    end

    assign cnt_x    = CMPW'(count_reg);
    assign lim_x    = CMPW'(output_limit);
    assign keep0    = e0_vld && (cnt_x < lim_x) && (count_reg != '1);
    assign count1   = count_reg + COUNT_WIDTH'(keep0);
    assign cnt1_x   = CMPW'(count1);
    assign keep1    = e1_vld && (cnt1_x < lim_x) && (count1 != '1);
    assign cnt_p1_x = cnt_x + CMPW'(1);
    assign cnt_p2_x = cnt_x + CMPW'(2);

    always_comb
    begin
        res = '0;
        if (keep0)
        begin
            res.r0.out_byte  = e0_byte;
            res.r0.has_byte  = 1'b1;
            res.r0.out_count = cnt_p1_x[15:0];
            res.n            = 2'd1;
            if (keep1)
            begin
                res.r1.out_byte  = e1_byte;
                res.r1.has_byte  = 1'b1;
                res.r1.out_count = cnt_p2_x[15:0];
                res.n            = 2'd2;
            end
        end
        else if (keep1)
        begin
            res.r0.out_byte  = e1_byte;
            res.r0.has_byte  = 1'b1;
            res.r0.out_count = cnt_p1_x[15:0];
            res.n            = 2'd1;
        end
        if (last)
        begin
            if (res.n == 2'd0)
            begin
                res.r0.out_count     = cnt_x[15:0];
                res.r0.end_of_string = 1'b1;
                res.n                = 2'd1;
            end
            else if (res.n == 2'd1)
            begin
                res.r0.end_of_string = 1'b1;
            end
            else
            begin
                res.r1.end_of_string = 1'b1;
            end
        end
    end

    assign count_next = last ? '0
                             : count1 + COUNT_WIDTH'(keep1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cesd_pkg::MODE_PLAIN;
            value_reg  <= 8'd0;
            digits_reg <= 2'd0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= last ? cesd_pkg::MODE_PLAIN : mode_next;
            value_reg  <= last ? 8'd0 : value_next;
            digits_reg <= last ? 2'd0 : digits_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cesd_res_queue.sv */
`default_nettype none

module cesd_res_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cesd_pkg::dec_res_t  res,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cesd_pkg::out_item_t      out_data
);

    cesd_pkg::out_item_t mem [cesd_pkg::QDEPTH];

    logic [cesd_pkg::QAW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [cesd_pkg::QCW-1:0] count_reg, count_next;
    logic [cesd_pkg::QAW-1:0] wr_ptr_inc;
    logic [1:0]               push_n;
    logic                     pop;

    assign push_n     = push ? res.n : 2'd0;
    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign room       = (count_reg <= cesd_pkg::QCW'(cesd_pkg::QDEPTH - 2));
    assign out_data   = mem[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + cesd_pkg::QAW'(1);

    assign wr_ptr_next = wr_ptr_reg + cesd_pkg::QAW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + cesd_pkg::QAW'(pop);
    assign count_next  = count_reg + cesd_pkg::QCW'(push_n) - cesd_pkg::QCW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= res.r0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_inc] <= res.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/c_escape_sequence_decoder_unit.sv */
`default_nettype none

// Decodes a C-escaped character stream, one character per request, into raw bytes.
// A character is taken every cycle while the result queue has room; it is decoded
// combinationally from the input register, and its results go into a four-entry
// result queue. A character yields zero, one or two results; the output port
// delivers one result per cycle from the queue while out_ready is high, so a
// character that closes a hex or octal escape and also produces a plain byte
// yields two results in turn, and input back-pressure follows when the queue has
// fewer than two free entries. output_limit must be written through the cfg port
// between strings, which is not enforced; results past the limit are dropped.
module c_escape_sequence_decoder_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cesd_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cesd_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data
);

    cesd_pkg::in_item_t in_reg;
    logic               in_vld_reg, in_vld_next;
    logic [15:0]        limit_reg;
    logic               fire;
    logic               room;
    cesd_pkg::dec_res_t res;

    assign cfg_ready   = 1'b1;
    assign fire        = in_vld_reg && room;
    assign in_ready    = !in_vld_reg || fire;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            limit_reg  <= 16'hFFFF;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    cesd_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (in_reg),
        .output_limit (limit_reg),
        .res          (res)
    );

    cesd_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_byte |-> out_data.end_of_string)
        else $error("bare marker without end of string");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_byte |-> out_data.out_byte == 8'd0)
        else $error("bare marker carries a byte");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> limit_reg == $past(cfg_data))
        else $error("limit register not updated");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && !room)
        else $error("input stalled without a full queue");

endmodule

`default_nettype wire
